// File: src/url_dec_pkg.sv
package url_dec_pkg;

    localparam logic [7:0] CHAR_PERCENT = 8'h25;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_UA      = 8'h41;
    localparam logic [7:0] CHAR_UF      = 8'h46;
    localparam logic [7:0] CHAR_LA      = 8'h61;
    localparam logic [7:0] CHAR_LF_HEX  = 8'h66;
    localparam logic [7:0] CHAR_CR      = 8'h0d;
    localparam logic [7:0] CHAR_NL      = 8'h0a;
    localparam logic [7:0] CHAR_NUL     = 8'h00;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'b001,
        PH_DIGIT1 = 3'b010,
        PH_DIGIT2 = 3'b100
    } phase_t;

    typedef struct packed {
        phase_t     phase;
        logic [3:0] upper_nibble;
        logic       error_seen;
    } dec_state_t;

    typedef struct packed {
        logic       emit;
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       path_error;
        logic       out_last;
    } dec_result_t;

    localparam dec_state_t STATE_RESET = '{
        phase:        PH_IDLE,
        upper_nibble: 4'h0,
        error_seen:   1'b0
    };

    // bit 4 set: not a hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] v;
        begin
            v = 5'h10;
            if (b >= CHAR_ZERO && b <= CHAR_NINE)
            begin
                v = {1'b0, 4'(b - CHAR_ZERO)};
            end
            else if (b >= CHAR_UA && b <= CHAR_UF)
            begin
                v = {1'b0, 4'(b - CHAR_UA + 8'd10)};
            end
            else if (b >= CHAR_LA && b <= CHAR_LF_HEX)
            begin
                v = {1'b0, 4'(b - CHAR_LA + 8'd10)};
            end
            return v;
        end
    endfunction

endpackage

// File: src/url_dec_core.sv
module url_dec_core (
    input  url_dec_pkg::dec_state_t  state,
    input  logic [7:0]               in_byte,
    input  logic                     in_last,
    output url_dec_pkg::dec_state_t  state_next,
    output url_dec_pkg::dec_result_t result
);

    logic [4:0] digit;
    logic [7:0] val;
    logic       have;
    url_dec_pkg::dec_state_t st;

    assign digit = url_dec_pkg::hex_value(in_byte);

    always_comb
    begin
        st   = state;
        val  = 8'h00;
        have = 1'b0;
        if (!state.error_seen)
        begin
            unique case (state.phase)
                url_dec_pkg::PH_DIGIT1:
                begin
                    if (digit[4])
                    begin
                        st.error_seen = 1'b1;
                    end
                    else
                    begin
                        st.upper_nibble = digit[3:0];
                        st.phase        = url_dec_pkg::PH_DIGIT2;
                    end
                end
                url_dec_pkg::PH_DIGIT2:
                begin
                    if (digit[4])
                    begin
                        st.error_seen = 1'b1;
                    end
                    else
                    begin
                        val             = {state.upper_nibble, digit[3:0]};
                        st.phase        = url_dec_pkg::PH_IDLE;
                        st.upper_nibble = 4'h0;
                        if (val == url_dec_pkg::CHAR_CR || val == url_dec_pkg::CHAR_NL ||
                            val == url_dec_pkg::CHAR_NUL || val == url_dec_pkg::CHAR_SPACE)
                        begin
                            st.error_seen = 1'b1;
                        end
                        else
                        begin
                            have = 1'b1;
                        end
                    end
                end
                default:
                begin
                    st.phase = url_dec_pkg::PH_IDLE;
                    if (in_byte == url_dec_pkg::CHAR_PERCENT)
                    begin
                        st.phase = url_dec_pkg::PH_DIGIT1;
                    end
                    else
                    begin
                        val  = in_byte;
                        have = 1'b1;
                    end
                end
            endcase
            if (in_last && st.phase != url_dec_pkg::PH_IDLE)
            begin
                st.error_seen = 1'b1;
            end
        end
    end

    always_comb
    begin
        result.out_byte   = (st.error_seen) ? 8'h00 : val;
        result.byte_valid = have && !st.error_seen;
        result.path_error = in_last && st.error_seen;
        result.out_last   = in_last;
        result.emit       = in_last || (have && !st.error_seen);
        state_next        = in_last ? url_dec_pkg::STATE_RESET : st;
    end

endmodule

// File: src/url_percent_decoder.sv
// Streaming percent decoder for URL path bytes. One byte is taken per clock
// on the in_valid/in_stall channel and at most one decoded word leaves per
// clock on out_valid/out_stall; the sustained rate is one byte per cycle
// while out_stall stays low. Each byte is held in the input register, then
// decoded into the output register. A '%' and its first hex digit give no
// word; the second digit gives the decoded byte. A bad digit,
// an escape cut off by in_last, or an escape that decodes to CR, LF, NUL or
// space marks the path in error and drops its remaining bytes. The byte with
// in_last always gives one word with out_last set and path_error telling
// whether the path was malformed; decoder state then returns to its reset value.
module url_percent_decoder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       path_error,
    output logic       out_last
);

    logic                      s1_valid_reg;
    logic                      s1_valid_next;
    logic [7:0]                s1_byte_reg;
    logic                      s1_last_reg;
    url_dec_pkg::dec_state_t   state_reg;
    url_dec_pkg::dec_state_t   state_next;
    url_dec_pkg::dec_result_t  result;
    url_dec_pkg::dec_result_t  out_reg;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic                      s1_adv;
    logic                      in_take;

    url_dec_core u_core (
        .state      (state_reg),
        .in_byte    (s1_byte_reg),
        .in_last    (s1_last_reg),
        .state_next (state_next),
        .result     (result)
    );

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_adv;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (s1_adv)
        begin
            out_valid_next = result.emit;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= url_dec_pkg::STATE_RESET;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_adv)
            begin
                state_reg <= state_next;
            end
        end
    end

    // payload: hold while stalled
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_byte_reg <= in_byte;
            s1_last_reg <= in_last;
        end
        if (s1_adv && result.emit)
        begin
            out_reg <= result;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_reg.out_byte;
    assign byte_valid = out_reg.byte_valid;
    assign path_error = out_reg.path_error;
    assign out_last   = out_reg.out_last;

endmodule

// File: tb/tb_top.sv
module tb_top;

    localparam int HALF_PERIOD    = 5;
    localparam int RANDOM_BYTES   = 1300;
    localparam int IDLE_PERCENT   = 23;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 16;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       err;
        logic       last;
    } dec_word_t;

    class url_decode_board;
        url_dec_pkg::phase_t esc_phase = url_dec_pkg::PH_IDLE;
        logic [3:0]  hi_nibble     = 4'h0;
        logic        path_bad      = 1'b0;
        dec_word_t   expected_words[$];
        int          mismatches    = 0;

        function logic [4:0] hex_digit(input logic [7:0] c);
            if (c inside {["0":"9"]})
            begin
                return {1'b0, c[3:0]};
            end
            if (c inside {["A":"F"], ["a":"f"]})
            begin
                return {1'b0, 4'(c[3:0] + 4'd9)};
            end
            return 5'h10;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        // predict the word, if any, that one accepted byte produces
        function void note_byte(input logic [7:0] b, input logic last);
            logic [4:0] d;
            logic [7:0] val;
            logic       have;
            val  = 8'h00;
            have = 1'b0;
            if (!path_bad)
            begin
                case (esc_phase)
                    url_dec_pkg::PH_DIGIT1:
                    begin
                        d = hex_digit(b);
                        if (d[4])
                        begin
                            path_bad = 1'b1;
                        end
                        else
                        begin
                            hi_nibble = d[3:0];
                            esc_phase = url_dec_pkg::PH_DIGIT2;
                        end
                    end
                    url_dec_pkg::PH_DIGIT2:
                    begin
                        d = hex_digit(b);
                        if (d[4])
                        begin
                            path_bad = 1'b1;
                        end
                        else
                        begin
                            val       = {hi_nibble, d[3:0]};
                            esc_phase = url_dec_pkg::PH_IDLE;
                            hi_nibble = 4'h0;
                            if (val == url_dec_pkg::CHAR_CR || val == url_dec_pkg::CHAR_NL
                                || val == url_dec_pkg::CHAR_NUL
                                || val == url_dec_pkg::CHAR_SPACE)
                            begin
                                path_bad = 1'b1;
                            end
                            else
                            begin
                                have = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        esc_phase = url_dec_pkg::PH_IDLE;
                        if (b == url_dec_pkg::CHAR_PERCENT)
                        begin
                            esc_phase = url_dec_pkg::PH_DIGIT1;
                        end
                        else
                        begin
                            val  = b;
                            have = 1'b1;
                        end
                    end
                endcase
                if (last && esc_phase != url_dec_pkg::PH_IDLE)
                begin
                    path_bad = 1'b1;
                end
            end
            if (last)
            begin
                if (path_bad)
                begin
                    expected_words.insert(expected_words.size(),
                                          dec_word_t'{8'h00, 1'b0, 1'b1, 1'b1});
                end
                else
                begin
                    expected_words.insert(expected_words.size(),
                                          dec_word_t'{val, have, 1'b0, 1'b1});
                end
                esc_phase = url_dec_pkg::PH_IDLE;
                hi_nibble = 4'h0;
                path_bad  = 1'b0;
            end
            else if (!path_bad && have)
            begin
                expected_words.insert(expected_words.size(),
                                      dec_word_t'{val, 1'b1, 1'b0, 1'b0});
            end
        endfunction

        task report(input string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_word(input logic [7:0] b, input logic v, input logic e, input logic l);
            dec_word_t w;
            if (expected_words.size() == 0)
            begin
                report($sformatf("unexpected word byte=%02h valid=%0b err=%0b last=%0b",
                                 b, v, e, l));
                return;
            end
            w = expected_words[0];
            expected_words.delete(0);
            if (b !== w.data)
            begin
                report($sformatf("out_byte %02h, want %02h", b, w.data));
            end
            if (v !== w.valid)
            begin
                report($sformatf("byte_valid %0b, want %0b", v, w.valid));
            end
            if (e !== w.err)
            begin
                report($sformatf("path_error %0b, want %0b", e, w.err));
            end
            if (l !== w.last)
            begin
                report($sformatf("out_last %0b, want %0b", l, w.last));
            end
        endtask
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] in_byte;
    logic       in_last;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       path_error;
    logic       out_last;

    url_decode_board sb = new;
    logic            steady = 1'b0;
    int              idle_cycles = 0;

    url_percent_decoder i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_byte    (in_byte),
        .in_last    (in_last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .path_error (path_error),
        .out_last   (out_last)
    );

    always #(HALF_PERIOD) clk = ~clk;

    always @(negedge clk)
    begin
        out_stall <= !steady && ($urandom_range(99) < IDLE_PERCENT);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_stall === 1'b0)
            begin
                sb.note_byte(in_byte, in_last);
            end
            if (out_valid && out_stall === 1'b0)
            begin
                sb.check_word(out_byte, byte_valid, path_error, out_last);
            end
            if ((in_valid && in_stall === 1'b0) || (out_valid && out_stall === 1'b0))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("url_percent_decoder regression: fail");
                $finish;
            end
        end
    end

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
        begin
            return url_dec_pkg::CHAR_ZERO + n;
        end
        return ($urandom_range(1) ? url_dec_pkg::CHAR_UA : url_dec_pkg::CHAR_LA)
               + (n - 4'd10);
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_byte(input logic [7:0] b, input logic last);
        while (!steady && $urandom_range(99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        in_last  <= last;
        @(posedge clk);
        while (in_stall !== 1'b0)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    initial
    begin
        logic [7:0] path[$];
        logic [7:0] v;
        logic [4:0] dg;
        int         units;
        int         kind;
        int         sent;
        int         paths;
        clk       = 1'b0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_byte   = 8'h00;
        in_last   = 1'b0;
        out_stall = 1'b0;
        sent      = 0;
        paths     = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // pass-through of special values, mixed-case escapes, escape ending the path
        send_byte(url_dec_pkg::CHAR_NUL, 1'b0);
        send_byte(url_dec_pkg::CHAR_CR, 1'b0);
        send_byte(url_dec_pkg::CHAR_NL, 1'b0);
        send_byte(url_dec_pkg::CHAR_SPACE, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(url_dec_pkg::CHAR_PERCENT, 1'b0);
        send_byte("f", 1'b0);
        send_byte("F", 1'b0);
        send_byte(url_dec_pkg::CHAR_PERCENT, 1'b0);
        send_byte("4", 1'b0);
        send_byte("a", 1'b1);
        // escape decoding to CR on the last byte
        send_byte(url_dec_pkg::CHAR_PERCENT, 1'b0);
        send_byte("0", 1'b0);
        send_byte("d", 1'b1);
        // bad first digit, then dropped bytes
        send_byte(url_dec_pkg::CHAR_PERCENT, 1'b0);
        send_byte("g", 1'b0);
        send_byte("x", 1'b1);
        // cut off right after the percent sign
        send_byte(url_dec_pkg::CHAR_PERCENT, 1'b1);
        // cut off after the first digit
        send_byte(url_dec_pkg::CHAR_PERCENT, 1'b0);
        send_byte("A", 1'b1);
        // decoded percent sign is not decoded again
        send_byte(url_dec_pkg::CHAR_PERCENT, 1'b0);
        send_byte("2", 1'b0);
        send_byte("5", 1'b0);
        send_byte("4", 1'b0);
        send_byte("1", 1'b1);
        // space from an escape in mid path
        send_byte(url_dec_pkg::CHAR_PERCENT, 1'b0);
        send_byte("2", 1'b0);
        send_byte("0", 1'b0);
        send_byte("k", 1'b1);

        while (sent < RANDOM_BYTES)
        begin
            path.delete();
            units = ($urandom_range(9) == 0) ? $urandom_range(40, 12) : $urandom_range(8, 1);
            for (int k = 0; k < units; k++)
            begin
                kind = $urandom_range(99);
                if (kind < 35)
                begin
                    v = 8'($urandom_range(255));
                    if ($urandom_range(19) == 0)
                    begin
                        case ($urandom_range(3))
                            0: v = url_dec_pkg::CHAR_CR;
                            1: v = url_dec_pkg::CHAR_NL;
                            2: v = url_dec_pkg::CHAR_NUL;
                            default: v = url_dec_pkg::CHAR_SPACE;
                        endcase
                    end
                    path.insert(path.size(), url_dec_pkg::CHAR_PERCENT);
                    path.insert(path.size(), hex_char(v[7:4]));
                    path.insert(path.size(), hex_char(v[3:0]));
                end
                else if (kind < 88)
                begin
                    v = 8'($urandom_range(255));
                    if (v == url_dec_pkg::CHAR_PERCENT)
                    begin
                        v = url_dec_pkg::CHAR_SPACE;
                    end
                    path.insert(path.size(), v);
                end
                else if (kind < 94)
                begin
                    path.insert(path.size(), url_dec_pkg::CHAR_PERCENT);
                    if ($urandom_range(1))
                    begin
                        path.insert(path.size(), hex_char(4'($urandom_range(15))));
                    end
                    do
                    begin
                        v  = 8'($urandom_range(255));
                        dg = sb.hex_digit(v);
                    end
                    while (!dg[4]);
                    path.insert(path.size(), v);
                end
                else
                begin
                    path.insert(path.size(), 8'($urandom_range(255)));
                end
            end
            if ($urandom_range(14) == 0)
            begin
                path.insert(path.size(), url_dec_pkg::CHAR_PERCENT);
                if ($urandom_range(1))
                begin
                    path.insert(path.size(), hex_char(4'($urandom_range(15))));
                end
            end
            for (int i = 0; i < path.size(); i++)
            begin
                send_byte(path[i], i == path.size() - 1);
            end
            sent += path.size();
            paths++;
            steady = (sent >= 500 && sent < 800);
            if (paths % 40 == 0)
            begin
                // hold until the decoder has drained
                in_valid <= 1'b0;
                do
                begin
                    @(negedge clk);
                end
                while (sb.pending() != 0);
            end
        end

        in_valid <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
        begin
            $display("url_percent_decoder regression: pass");
        end
        else
        begin
            $display("url_percent_decoder regression: fail");
        end
        $finish;
    end

endmodule
